// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl files
// each use expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define FSG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define FSG_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fsg_pkg.sv
`default_nettype none
package fsg_pkg;

    localparam int MAX_TASKS   = 64;
    localparam int TIME_BITS   = 24;
    localparam int ID_BITS     = 6;
    localparam int ID_SPAN     = 1 << ID_BITS;
    localparam int FIELD_BITS  = 24;
    localparam int ADDR_BITS   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_TASKS + 1);
    localparam int CLK_BITS    = TIME_BITS + CNT_BITS + 1;
    localparam int ENTRY_BITS  = 2 * TIME_BITS + ID_BITS;

    typedef enum logic [1:0] {
        EV_WAIT   = 2'd0,
        EV_CREATE = 2'd1,
        EV_EXEC   = 2'd2,
        EV_NONE   = 2'd3
    } ev_kind_t;

    typedef enum logic [1:0] {
        SUB_ENTER,
        SUB_SPLIT,
        SUB_FINISH
    } sub_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_CMP,
        ST_LD_PUT,
        ST_F_EMIT,
        ST_W_TOP,
        ST_W_ERD,
        ST_W_ENT,
        ST_W_SCRD,
        ST_W_SC,
        ST_W_ENDENT,
        ST_W_SRD,
        ST_W_SPL
    } state_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] arr;
        logic [TIME_BITS-1:0] rem;
        logic [ID_BITS-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic                 func;
        entry_t               task_e;
    } item_t;

    typedef struct packed {
        logic                  valid;
        ev_kind_t              kind;
        logic [FIELD_BITS-1:0] amount;
        logic [ID_BITS-1:0]    task_id;
        logic                  last;
    } result_t;

    // fit a time value onto the fixed 24 bit amount field
    function automatic logic [FIELD_BITS-1:0] to_amount(input logic [TIME_BITS-1:0] v);
        logic [TIME_BITS+FIELD_BITS-1:0] tmp;
        tmp = {{FIELD_BITS{1'b0}}, v};
        return tmp[FIELD_BITS-1:0];
    endfunction

    // fit a 24 bit input field onto the internal time width
    function automatic logic [TIME_BITS-1:0] to_time(input logic [FIELD_BITS-1:0] v);
        logic [TIME_BITS+FIELD_BITS-1:0] tmp;
        tmp = {{TIME_BITS{1'b0}}, v};
        return tmp[TIME_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/fsg_ram.sv
`default_nettype none
module fsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/fsg_ctrl.sv
`default_nettype none
module fsg_ctrl
    import fsg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_take,
    input  wire item_t   item,
    output logic         idle,
    output result_t      res
);

    `include "assert_macros.svh"

    state_t                  state_reg, state_next;
    logic [CNT_BITS-1:0]     count_reg;
    logic                    walking_reg;
    logic [ID_SPAN-1:0]      created_reg;
    logic [CNT_BITS-1:0]     pos_reg;
    sub_t                    sub_reg;
    logic [CNT_BITS-1:0]     sidx_reg;
    logic [CNT_BITS-1:0]     send_reg;
    logic [CNT_BITS-1:0]     scan_reg;
    logic [CNT_BITS-1:0]     p_reg;
    logic [CLK_BITS-1:0]     now_reg;
    logic [CLK_BITS-1:0]     seg_reg;
    logic                    pend_v_reg;
    logic [ID_BITS-1:0]      pend_id_reg;
    logic [TIME_BITS-1:0]    cur_rem_reg;
    logic [ID_BITS-1:0]      cur_id_reg;
    logic                    hv_reg;
    ev_kind_t                hv_kind_reg;
    logic [FIELD_BITS-1:0]   hv_amt_reg;
    logic [ID_BITS-1:0]      hv_id_reg;
    logic                    look_v_reg;
    ev_kind_t                look_kind_reg;
    logic [FIELD_BITS-1:0]   look_amt_reg;
    logic [ID_BITS-1:0]      look_id_reg;
    logic                    second_reg;
    entry_t                  nw_reg;
    result_t                 res_reg;

    logic                    ram_we;
    logic [ADDR_BITS-1:0]    ram_waddr;
    logic [ENTRY_BITS-1:0]   ram_wdata;
    logic [ADDR_BITS-1:0]    ram_raddr;
    logic [ENTRY_BITS-1:0]   ram_rdata;
    entry_t                  rd;

    logic [CLK_BITS-1:0]     rd_arr_x;
    logic [CLK_BITS-1:0]     rd_rem_x;
    logic                    late;
    logic [CLK_BITS-1:0]     wt;
    logic [CLK_BITS-1:0]     seg_new;
    logic [CLK_BITS-1:0]     rt;
    logic                    rt_nz;
    logic                    sc_pass;
    logic                    spl_done;
    logic                    ld_shift;
    logic [CNT_BITS-1:0]     p_dec;
    logic [CNT_BITS-1:0]     count_eff;

    logic                    fin;
    logic                    fin_v;
    ev_kind_t                fin_kind;
    logic [FIELD_BITS-1:0]   fin_amt;
    logic [ID_BITS-1:0]      fin_id;

    // task store: arrival, remaining run time and id per entry
    fsg_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_TASKS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // comparisons on the entry just read
    always_comb
    begin
        rd        = entry_t'(ram_rdata);
        rd_arr_x  = {{(CLK_BITS-TIME_BITS){1'b0}}, rd.arr};
        rd_rem_x  = {{(CLK_BITS-TIME_BITS){1'b0}}, rd.rem};
        late      = rd_arr_x > now_reg;
        wt        = late ? (rd_arr_x - now_reg) : '0;
        seg_new   = late ? rd_arr_x : now_reg;
        rt        = rd_arr_x - seg_reg;
        rt_nz     = rt != '0;
        sc_pass   = (rd_arr_x <= now_reg) && (rd_arr_x >= seg_reg);
        spl_done  = sidx_reg >= send_reg;
        ld_shift  = rd.arr > nw_reg.arr;
        p_dec     = p_reg - CNT_BITS'(1);
        count_eff = walking_reg ? '0 : count_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (item.func)
                    begin
                        state_next = walking_reg ? ST_F_EMIT : ST_W_TOP;
                    end
                    else if (count_eff < CNT_BITS'(MAX_TASKS))
                    begin
                        state_next = (count_eff == '0) ? ST_LD_PUT : ST_LD_RD;
                    end
                end
            end
            ST_LD_RD:    state_next = ST_LD_CMP;
            ST_LD_CMP:
            begin
                if (ld_shift)
                begin
                    state_next = (p_dec == '0) ? ST_LD_PUT : ST_LD_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LD_PUT:   state_next = ST_IDLE;
            ST_F_EMIT:   state_next = look_v_reg ? ST_W_TOP : ST_IDLE;
            ST_W_TOP:
            begin
                if (!fin)
                begin
                    if (sub_reg == SUB_ENTER)
                    begin
                        state_next = ST_W_ERD;
                    end
                    else if (sub_reg == SUB_SPLIT && !spl_done)
                    begin
                        state_next = ST_W_SRD;
                    end
                end
            end
            ST_W_ERD:    state_next = ST_W_ENT;
            ST_W_ENT:    state_next = ST_W_SCRD;
            ST_W_SCRD:   state_next = (scan_reg < count_reg) ? ST_W_SC : ST_W_ENDENT;
            ST_W_SC:     state_next = sc_pass ? ST_W_SCRD : ST_W_ENDENT;
            ST_W_ENDENT: state_next = hv_reg ? ST_W_ENDENT : ST_W_TOP;
            ST_W_SRD:    state_next = ST_W_SPL;
            ST_W_SPL:    state_next = ST_W_TOP;
            default:     state_next = ST_IDLE;
        endcase
        if (fin)
        begin
            state_next = second_reg ? ST_IDLE : ST_F_EMIT;
        end
    end

    // memory access and walk completion
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = p_reg[ADDR_BITS-1:0];
        ram_wdata = nw_reg;
        ram_raddr = p_dec[ADDR_BITS-1:0];
        fin       = 1'b0;
        fin_v     = 1'b1;
        fin_kind  = EV_NONE;
        fin_amt   = '0;
        fin_id    = '0;
        case (state_reg)
            ST_LD_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = ld_shift ? rd : nw_reg;
            end
            ST_LD_PUT:
            begin
                ram_we = 1'b1;
            end
            ST_W_TOP:
            begin
                if (pend_v_reg)
                begin
                    fin      = 1'b1;
                    fin_kind = EV_CREATE;
                    fin_id   = pend_id_reg;
                end
                else if (pos_reg >= count_reg)
                begin
                    fin   = 1'b1;
                    fin_v = 1'b0;
                end
                else if (sub_reg == SUB_FINISH && cur_rem_reg != '0)
                begin
                    fin      = 1'b1;
                    fin_kind = EV_EXEC;
                    fin_amt  = to_amount(cur_rem_reg);
                    fin_id   = cur_id_reg;
                end
            end
            ST_W_ERD:    ram_raddr = pos_reg[ADDR_BITS-1:0];
            ST_W_SCRD:   ram_raddr = scan_reg[ADDR_BITS-1:0];
            ST_W_SRD:    ram_raddr = sidx_reg[ADDR_BITS-1:0];
            ST_W_ENDENT:
            begin
                if (hv_reg)
                begin
                    fin      = 1'b1;
                    fin_kind = hv_kind_reg;
                    fin_amt  = hv_amt_reg;
                    fin_id   = hv_id_reg;
                end
            end
            ST_W_SPL:
            begin
                if (!created_reg[rd.id])
                begin
                    fin = 1'b1;
                    if (rt_nz)
                    begin
                        fin_kind = EV_EXEC;
                        fin_amt  = to_amount(rt[TIME_BITS-1:0]);
                        fin_id   = cur_id_reg;
                    end
                    else
                    begin
                        fin_kind = EV_CREATE;
                        fin_id   = rd.id;
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            walking_reg <= 1'b0;
            created_reg <= '0;
            pos_reg     <= '0;
            sub_reg     <= SUB_ENTER;
            sidx_reg    <= '0;
            send_reg    <= '0;
            pend_v_reg  <= 1'b0;
            look_v_reg  <= 1'b0;
            hv_reg      <= 1'b0;
            second_reg  <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg.valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        second_reg <= 1'b0;
                        if (item.func)
                        begin
                            if (!walking_reg)
                            begin
                                walking_reg <= 1'b1;
                                pos_reg     <= '0;
                                sub_reg     <= SUB_ENTER;
                                pend_v_reg  <= 1'b0;
                            end
                        end
                        else if (walking_reg)
                        begin
                            count_reg   <= '0;
                            created_reg <= '0;
                            walking_reg <= 1'b0;
                            look_v_reg  <= 1'b0;
                            pos_reg     <= '0;
                            sub_reg     <= SUB_ENTER;
                            pend_v_reg  <= 1'b0;
                        end
                    end
                end
                ST_LD_CMP:
                begin
                    if (!ld_shift)
                    begin
                        count_reg <= count_reg + CNT_BITS'(1);
                    end
                end
                ST_LD_PUT:
                begin
                    count_reg <= count_reg + CNT_BITS'(1);
                end
                ST_F_EMIT:
                begin
                    second_reg    <= 1'b1;
                    res_reg.valid <= !look_v_reg;
                    res_reg.kind  <= look_v_reg ? look_kind_reg : EV_NONE;
                    res_reg.amount  <= look_v_reg ? look_amt_reg : '0;
                    res_reg.task_id <= look_v_reg ? look_id_reg : '0;
                    res_reg.last  <= 1'b1;
                end
                ST_W_TOP:
                begin
                    if (pend_v_reg)
                    begin
                        pend_v_reg <= 1'b0;
                    end
                    else if (pos_reg < count_reg)
                    begin
                        if (sub_reg == SUB_SPLIT && spl_done)
                        begin
                            sub_reg <= SUB_FINISH;
                        end
                        else if (sub_reg == SUB_FINISH)
                        begin
                            sub_reg <= SUB_ENTER;
                            pos_reg <= pos_reg + CNT_BITS'(1);
                        end
                    end
                end
                ST_W_ENT:
                begin
                    hv_reg <= late || (rd_arr_x == now_reg && pos_reg == '0);
                    if (late)
                    begin
                        pend_v_reg <= 1'b1;
                    end
                    if (late || (rd_arr_x == now_reg && pos_reg == '0))
                    begin
                        created_reg[rd.id] <= 1'b1;
                    end
                end
                ST_W_SCRD:
                begin
                    if (scan_reg >= count_reg)
                    begin
                        send_reg <= scan_reg;
                    end
                end
                ST_W_SC:
                begin
                    if (!sc_pass)
                    begin
                        send_reg <= scan_reg;
                    end
                end
                ST_W_ENDENT:
                begin
                    sidx_reg <= pos_reg + CNT_BITS'(1);
                    sub_reg  <= SUB_SPLIT;
                    hv_reg   <= 1'b0;
                end
                ST_W_SRD:
                begin
                    sidx_reg <= sidx_reg + CNT_BITS'(1);
                end
                ST_W_SPL:
                begin
                    if (!created_reg[rd.id])
                    begin
                        created_reg[rd.id] <= 1'b1;
                        if (rt_nz)
                        begin
                            pend_v_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    second_reg <= second_reg;
                end
            endcase
            // walk result: fill the lookahead, and on the second walk deliver
            if (fin)
            begin
                look_v_reg <= fin_v;
                if (second_reg)
                begin
                    res_reg.valid <= 1'b1;
                    res_reg.last  <= !fin_v;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            look_kind_reg <= fin_kind;
            look_amt_reg  <= fin_amt;
            look_id_reg   <= fin_id;
        end
        case (state_reg)
            ST_IDLE:
            begin
                nw_reg  <= item.task_e;
                p_reg   <= count_eff;
                now_reg <= walking_reg ? now_reg : '0;
                seg_reg <= walking_reg ? seg_reg : '0;
            end
            ST_LD_CMP:
            begin
                if (ld_shift)
                begin
                    p_reg <= p_dec;
                end
            end
            ST_W_ENT:
            begin
                seg_reg     <= seg_new;
                now_reg     <= seg_new + rd_rem_x;
                cur_rem_reg <= rd.rem;
                cur_id_reg  <= rd.id;
                scan_reg    <= pos_reg + CNT_BITS'(1);
                pend_id_reg <= rd.id;
                hv_kind_reg <= late ? EV_WAIT : EV_CREATE;
                hv_amt_reg  <= late ? to_amount(wt[TIME_BITS-1:0]) : '0;
                hv_id_reg   <= late ? '0 : rd.id;
            end
            ST_W_SC:
            begin
                if (sc_pass)
                begin
                    scan_reg <= scan_reg + CNT_BITS'(1);
                end
            end
            ST_W_SPL:
            begin
                if (!created_reg[rd.id])
                begin
                    seg_reg     <= rd_arr_x;
                    pend_id_reg <= rd.id;
                    if (rt_nz)
                    begin
                        cur_rem_reg <= cur_rem_reg - rt[TIME_BITS-1:0];
                    end
                end
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

    assign idle = state_reg == ST_IDLE;
    assign res  = res_reg;

    `FSG_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_BITS'(MAX_TASKS),
        "task count beyond capacity")
    `FSG_ASSERT_ALWAYS(a_pos_bound, pos_reg <= count_reg,
        "walk position beyond task count")
    `FSG_ASSERT_IMPLIES(a_split_bound, sub_reg == SUB_SPLIT, send_reg <= count_reg,
        "split bound beyond task count")

endmodule
`default_nettype wire

// File: rtl/core/fifo_schedule_event_generator.sv
// load: an entry goes straight into an empty store, else each stored task with a later arrival is moved past
// fetch: the lookahead is emitted first; a walk then enters a task, scans stored tasks,
// checks split candidates and takes finish steps; the first fetch of a set walks twice
// throughput: one item at a time, the input waits for the walk and for the output register to empty
// reset: rst_n clears the task count, created map, walk and output valid, store contents undefined
// no clearing pass: entries are only read below the task count
`default_nettype none
module fifo_schedule_event_generator
    import fsg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // arrival_time, run_time, task_id, zero pad
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // event_kind, amount, event_task
    output logic             m_tlast    // last_event
);

    `include "assert_macros.svh"

    logic                  ctrl_idle;
    logic                  take;
    item_t                 item;
    result_t               res;
    logic                  m_tvalid_reg;
    ev_kind_t              kind_reg;
    logic [FIELD_BITS-1:0] amount_reg;
    logic [ID_BITS-1:0]    task_reg;
    logic                  last_reg;

    // input transfer while the controller idles and the output is empty
    assign s_tready = ctrl_idle && !m_tvalid_reg && !res.valid;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        item.func        = s_tuser;
        item.task_e.arr  = to_time(s_tdata[23:0]);
        item.task_e.rem  = to_time(s_tdata[47:24]);
        item.task_e.id   = s_tdata[53:48];
    end

    fsg_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_take (take),
        .item    (item),
        .idle    (ctrl_idle),
        .res     (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            kind_reg   <= res.kind;
            amount_reg <= res.amount;
            task_reg   <= res.task_id;
            last_reg   <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {task_reg, amount_reg, kind_reg};
    assign m_tlast  = last_reg;

    `FSG_ASSERT_IMPLIES(a_res_into_empty, res.valid, !m_tvalid_reg,
        "result produced while output register full")
    `FSG_ASSERT_IMPLIES(a_none_is_last, m_tvalid_reg && kind_reg == EV_NONE, last_reg,
        "none event without last")

endmodule
`default_nettype wire
